[sv/mtm_pkg.sv]
package mtm_pkg;

  localparam int unsigned QueueDepthDefault = 32;
  localparam int unsigned PeerBitsDefault   = 10;
  localparam int unsigned TagBitsDefault    = 16;
  localparam int unsigned HandleBits        = 16;

  typedef enum logic {
    CMD_POST   = 1'b0,
    CMD_ARRIVE = 1'b1
  } cmd_e;

  // result word from the back end
  typedef struct packed {
    logic                  matched;
    logic [HandleBits-1:0] matched_handle;
    logic                  queued;
    logic                  overflow;
  } result_t;

endpackage

[sv/mtm_front.sv]
// input stage and two-entry queue of classified commands
module mtm_front #(
  parameter int unsigned PeerBits = mtm_pkg::PeerBitsDefault,
  parameter int unsigned TagBits  = mtm_pkg::TagBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [PeerBits-1:0]           peer_i,
  input  logic [TagBits-1:0]            tag_i,
  input  logic                          wild_src_i,
  input  logic                          any_tag_i,
  input  logic                          keep_i,
  input  logic [mtm_pkg::HandleBits-1:0] handle_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output logic [PeerBits+TagBits+mtm_pkg::HandleBits+3:0] cmd_word_o
);

  localparam int unsigned WordBits = PeerBits + TagBits + mtm_pkg::HandleBits + 4;

  logic [WordBits-1:0] mem_q [2];
  logic                wr_q, rd_q;
  logic [1:0]          cnt_q;
  logic [WordBits-1:0] word;
  logic                push, pop;

  // classify: wildcards only apply to receives, keep only to arrivals
  assign word = {cmd_i, peer_i, tag_i,
                 wild_src_i & (cmd_i == mtm_pkg::CMD_POST),
                 any_tag_i & (cmd_i == mtm_pkg::CMD_POST),
                 keep_i & (cmd_i == mtm_pkg::CMD_ARRIVE), handle_i};

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i & in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o & cmd_ready_i;
  assign cmd_word_o  = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= word;
  end

endmodule

[sv/mtm_queue.sv]
// ordered match queue: parallel compare, oldest hit, shift-remove or append
module mtm_queue #(
  parameter int unsigned Depth    = mtm_pkg::QueueDepthDefault,
  parameter int unsigned PeerBits = mtm_pkg::PeerBitsDefault,
  parameter int unsigned TagBits  = mtm_pkg::TagBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           search_i,
  input  logic [PeerBits-1:0]            peer_i,
  input  logic [TagBits-1:0]             tag_i,
  input  logic                           wsrc_i,
  input  logic                           wtag_i,
  output logic                           hit_o,
  output logic [$clog2(Depth)-1:0]       hit_idx_o,
  output logic [mtm_pkg::HandleBits-1:0] hit_handle_o,
  output logic                           full_o,
  input  logic                           remove_i,
  input  logic [$clog2(Depth)-1:0]       remove_idx_i,
  input  logic                           append_i,
  input  logic                           app_wsrc_i,
  input  logic                           app_wtag_i,
  input  logic [mtm_pkg::HandleBits-1:0] app_handle_i
);

  localparam int unsigned IdxBits = $clog2(Depth);
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [PeerBits-1:0]            peer_q   [Depth];
  logic [TagBits-1:0]             tag_q    [Depth];
  logic                           wsrc_q   [Depth];
  logic                           wtag_q   [Depth];
  logic [mtm_pkg::HandleBits-1:0] handle_q [Depth];
  logic [Depth-1:0]               vld_q;
  logic [CntBits-1:0]             cnt_q;
  logic [Depth-1:0]               hits_q;
  logic [Depth-1:0]               hits_d;

  assign full_o = (cnt_q == CntBits'(Depth));

  // compare every cell; stored or searching wildcards both mask
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      hits_d[i] = vld_q[i] & ((wsrc_i | wsrc_q[i]) | (peer_q[i] == peer_i))
                           & ((wtag_i | wtag_q[i]) | (tag_q[i] == tag_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (search_i) hits_q <= hits_d;
  end

  // priority pick of the oldest hit
  always_comb begin
    hit_o        = 1'b0;
    hit_idx_o    = '0;
    hit_handle_o = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (hits_q[i]) begin
        hit_o        = 1'b1;
        hit_idx_o    = IdxBits'(i);
        hit_handle_o = handle_q[i];
      end
    end
  end

  // valid bits and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      cnt_q <= '0;
    end else if (remove_i) begin
      vld_q <= {1'b0, vld_q[Depth-1:1]};
      cnt_q <= cnt_q - 1'b1;
    end else if (append_i) begin
      vld_q <= {vld_q[Depth-2:0], 1'b1};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // payload shift or append
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      if (remove_i) begin
        if (IdxBits'(i) >= remove_idx_i && i < Depth - 1) begin
          peer_q[i]   <= peer_q[i+1];
          tag_q[i]    <= tag_q[i+1];
          wsrc_q[i]   <= wsrc_q[i+1];
          wtag_q[i]   <= wtag_q[i+1];
          handle_q[i] <= handle_q[i+1];
        end
      end else if (append_i && cnt_q == CntBits'(i)) begin
        peer_q[i]   <= peer_i;
        tag_q[i]    <= tag_i;
        wsrc_q[i]   <= app_wsrc_i;
        wtag_q[i]   <= app_wtag_i;
        handle_q[i] <= app_handle_i;
      end
    end
  end

endmodule

[sv/mtm_back.sv]
// back end: compare cycle, then resolve into queue update and result word
module mtm_back #(
  parameter int unsigned Depth    = mtm_pkg::QueueDepthDefault,
  parameter int unsigned PeerBits = mtm_pkg::PeerBitsDefault,
  parameter int unsigned TagBits  = mtm_pkg::TagBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  logic [PeerBits+TagBits+mtm_pkg::HandleBits+3:0] cmd_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mtm_pkg::result_t     result_o
);

  localparam int unsigned HB = mtm_pkg::HandleBits;

  logic                cmd;
  logic [PeerBits-1:0] peer;
  logic [TagBits-1:0]  tag;
  logic                wsrc, wtag, keep;
  logic [HB-1:0]       handle;

  assign {cmd, peer, tag, wsrc, wtag, keep, handle} = cmd_word_i;

  logic busy_q;
  logic out_vld_q;
  mtm_pkg::result_t res_q;
  logic start, resolve;
  logic is_arr;

  logic rq_hit, uq_hit, rq_full, uq_full;
  logic [$clog2(Depth)-1:0] rq_idx, uq_idx;
  logic [HB-1:0] rq_h, uq_h;
  logic hit, full;
  logic rq_rm, uq_rm, rq_app, uq_app;

  assign is_arr  = (cmd == mtm_pkg::CMD_ARRIVE);
  assign start   = cmd_valid_i & ~busy_q;
  assign resolve = busy_q & (~out_vld_q | out_ready_i);
  assign cmd_ready_o = resolve;

  assign hit  = is_arr ? rq_hit : uq_hit;
  assign full = is_arr ? uq_full : rq_full;
  assign rq_rm  = resolve &  is_arr & rq_hit & ~keep;
  assign uq_rm  = resolve & ~is_arr & uq_hit;
  assign uq_app = resolve &  is_arr & ~rq_hit & ~uq_full;
  assign rq_app = resolve & ~is_arr & ~uq_hit & ~rq_full;

  // posted receive queue, searched by arrivals
  mtm_queue #(.Depth(Depth), .PeerBits(PeerBits), .TagBits(TagBits)) u_rq (
    .clk_i, .rst_ni,
    .search_i(start), .peer_i(peer), .tag_i(tag), .wsrc_i(1'b0), .wtag_i(1'b0),
    .hit_o(rq_hit), .hit_idx_o(rq_idx), .hit_handle_o(rq_h), .full_o(rq_full),
    .remove_i(rq_rm), .remove_idx_i(rq_idx), .append_i(rq_app),
    .app_wsrc_i(wsrc), .app_wtag_i(wtag), .app_handle_i(handle)
  );

  // unexpected queue, searched by receives with their own wildcards
  mtm_queue #(.Depth(Depth), .PeerBits(PeerBits), .TagBits(TagBits)) u_uq (
    .clk_i, .rst_ni,
    .search_i(start), .peer_i(peer), .tag_i(tag), .wsrc_i(wsrc), .wtag_i(wtag),
    .hit_o(uq_hit), .hit_idx_o(uq_idx), .hit_handle_o(uq_h), .full_o(uq_full),
    .remove_i(uq_rm), .remove_idx_i(uq_idx), .append_i(uq_app),
    .app_wsrc_i(1'b0), .app_wtag_i(1'b0), .app_handle_i(handle)
  );

  // busy flag and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (start) busy_q <= 1'b1;
      else if (resolve) busy_q <= 1'b0;
      if (resolve) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resolve) begin
      res_q.matched        <= hit;
      res_q.matched_handle <= hit ? (is_arr ? rq_h : uq_h) : '0;
      res_q.queued         <= ~hit & ~full;
      res_q.overflow       <= ~hit & full;
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = res_q;

endmodule

[sv/message_tag_matcher_core.sv]
// channel | handshake            | payload
// in      | in_valid_i/in_ready_o | cmd, peer, msg_tag, wild_src, any_tag,
//         |                      | keep_on_match, handle
// out     | out_valid_o/out_ready_i | matched, matched_handle, queued, overflow
//
// in the back end a word is first compared against all queue cells, then
// resolved by the oldest-hit pick and the shift-remove or append
// a two-entry command queue feeds the back end; reset empties both match
// queues through their valid bits, no clearing pass
// the back end holds a word while the output register is still occupied
module message_tag_matcher_core #(
  parameter int unsigned QueueDepth = mtm_pkg::QueueDepthDefault,
  parameter int unsigned PeerBits   = mtm_pkg::PeerBitsDefault,
  parameter int unsigned TagBits    = mtm_pkg::TagBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [PeerBits-1:0]            peer_i,
  input  logic [TagBits-1:0]             msg_tag_i,
  input  logic                           wild_src_i,
  input  logic                           any_tag_i,
  input  logic                           keep_on_match_i,
  input  logic [mtm_pkg::HandleBits-1:0] handle_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           matched_o,
  output logic [mtm_pkg::HandleBits-1:0] matched_handle_o,
  output logic                           queued_o,
  output logic                           overflow_o
);

  logic cmd_valid, cmd_ready;
  logic [PeerBits+TagBits+mtm_pkg::HandleBits+3:0] cmd_word;
  mtm_pkg::result_t res;

  mtm_front #(.PeerBits(PeerBits), .TagBits(TagBits)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .cmd_i, .peer_i, .tag_i(msg_tag_i), .wild_src_i, .any_tag_i,
    .keep_i(keep_on_match_i), .handle_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_word_o(cmd_word)
  );

  mtm_back #(.Depth(QueueDepth), .PeerBits(PeerBits), .TagBits(TagBits)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_word_i(cmd_word), .out_valid_o, .out_ready_i, .result_o(res)
  );

  assign matched_o        = res.matched;
  assign matched_handle_o = res.matched_handle;
  assign queued_o         = res.queued;
  assign overflow_o       = res.overflow;

`ifndef ASSERT_OFF
  // exactly one outcome per result word
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({matched_o, queued_o, overflow_o}))
    else $error("result word has not exactly one outcome");
  // no handle without a match
  a_handle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !matched_o) |-> (matched_handle_o == '0))
    else $error("handle set without match");
  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(res)))
    else $error("stalled result changed");
`endif

endmodule
